@@ hw/rtl/vp8rtp_pkg.sv @@
// Shared types and constants for the VP8 RTP packetiser.
// No dependencies; used by every module in hw/rtl.
package vp8rtp_pkg;

	localparam int unsigned DescBytes = 4;
	localparam int unsigned CmdqDepth = 4;
	localparam int unsigned CmdqAw = $clog2(CmdqDepth);

	localparam logic [15:0] PacketSizeMin = 16'd5;
	localparam logic [15:0] PacketSizeReset = 16'd1200;
	localparam logic [15:0] RoomReset = PacketSizeReset - 16'(DescBytes);

	localparam logic [7:0] DescHighBit = 8'h80;
	localparam logic [7:0] PidHighMask = 8'h7f;
	localparam logic [7:0] ByteMask = 8'hff;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_of_chunk;
		logic       final_chunk_of_picture;
		logic       is_keyframe;
		logic       first_of_picture;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_packet;
		logic       marker;
		logic       last_of_run;
	} out_item_t;

	// one classified byte: payload plus what the back end needs for the descriptor
	typedef struct packed {
		logic [7:0]  data_byte;
		logic        eop;
		logic        mk;
		logic        hdr;
		logic        noref;
		logic        start;
		logic [14:0] pid;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} cmdq_stat_t;

endpackage

@@ hw/rtl/vp8rtp_front.sv @@
// Front end: takes bytes, tracks packet fill and picture ID, classifies each word.
// Depends on vp8rtp_pkg.
module vp8rtp_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  vp8rtp_pkg::in_item_t   item,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_data,
	input  vp8rtp_pkg::cmdq_stat_t q_stat,
	output logic                   q_wr,
	output vp8rtp_pkg::cmd_t       q_cmd
);

	logic [15:0] room_q;
	logic [15:0] fill_q;
	logic [14:0] pid_q;
	logic        first_pkt_q;

	logic [14:0] pid_next;
	logic [15:0] fill_inc;
	logic        close;

	assign q_wr     = push && !q_stat.full;
	assign pid_next = item.first_of_picture ? pid_q + 15'd1 : pid_q;
	assign fill_inc = fill_q + 16'd1;
	assign close    = item.last_of_chunk || (fill_inc >= room_q);

	always_comb begin
		q_cmd.data_byte = item.data_byte;
		q_cmd.eop       = close;
		q_cmd.mk        = item.last_of_chunk && item.final_chunk_of_picture;
		q_cmd.hdr       = (fill_q == 16'd0);
		q_cmd.noref     = !item.is_keyframe;
		q_cmd.start     = first_pkt_q;
		q_cmd.pid       = pid_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_q      <= vp8rtp_pkg::RoomReset;
			fill_q      <= '0;
			pid_q       <= '0;
			first_pkt_q <= 1'b1;
		end else begin
			// payload room kept ready so the per-byte compare is a single one
			if (cfg_we) begin
				if (cfg_data < vp8rtp_pkg::PacketSizeMin)
					room_q <= vp8rtp_pkg::PacketSizeMin - 16'(vp8rtp_pkg::DescBytes);
				else
					room_q <= cfg_data - 16'(vp8rtp_pkg::DescBytes);
			end
			if (q_wr) begin
				pid_q  <= pid_next;
				fill_q <= close ? 16'd0 : fill_inc;
				if (item.last_of_chunk)
					first_pkt_q <= 1'b1;
				else if (close)
					first_pkt_q <= 1'b0;
			end
		end
	end

	property p_fill_below_room;
		@(posedge clk) disable iff (!arst_n)
		(q_wr && !close) |=> (fill_q != 16'd0);
	endproperty
	a_fill_below_room: assert property (p_fill_below_room)
		else $error("open packet lost its fill");

	property p_chunk_end_resets;
		@(posedge clk) disable iff (!arst_n)
		(q_wr && item.last_of_chunk) |=> (fill_q == 16'd0) && first_pkt_q;
	endproperty
	a_chunk_end_resets: assert property (p_chunk_end_resets)
		else $error("chunk end did not reopen packet state");

	property p_no_write_full;
		@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_wr;
	endproperty
	a_no_write_full: assert property (p_no_write_full)
		else $error("write into full queue");

endmodule

@@ hw/rtl/vp8rtp_cmdq.sv @@
// Short word queue between front and back ends, show-ahead read.
// Depends on vp8rtp_pkg.
module vp8rtp_cmdq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr,
	input  vp8rtp_pkg::cmd_t       wr_cmd,
	input  logic                   rd,
	output vp8rtp_pkg::cmd_t       rd_cmd,
	output vp8rtp_pkg::cmdq_stat_t stat
);

	vp8rtp_pkg::cmd_t                slot_q [vp8rtp_pkg::CmdqDepth];
	logic [vp8rtp_pkg::CmdqAw-1:0]   wr_ptr_q;
	logic [vp8rtp_pkg::CmdqAw-1:0]   rd_ptr_q;
	logic [vp8rtp_pkg::CmdqAw:0]     count_q;

	assign stat.full  = (count_q == (vp8rtp_pkg::CmdqAw+1)'(vp8rtp_pkg::CmdqDepth));
	assign stat.empty = (count_q == '0);
	assign rd_cmd     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			slot_q[wr_ptr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (wr && !rd)
				count_q <= count_q + 1'b1;
			else if (rd && !wr)
				count_q <= count_q - 1'b1;
		end
	end

	property p_ptr_count;
		@(posedge clk) disable iff (!arst_n)
		count_q[vp8rtp_pkg::CmdqAw-1:0] == (wr_ptr_q - rd_ptr_q);
	endproperty
	a_ptr_count: assert property (p_ptr_count)
		else $error("queue pointers and count disagree");

	property p_no_read_empty;
		@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !rd;
	endproperty
	a_no_read_empty: assert property (p_no_read_empty)
		else $error("read from empty queue");

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n)
		count_q <= (vp8rtp_pkg::CmdqAw+1)'(vp8rtp_pkg::CmdqDepth);
	endproperty
	a_count_bound: assert property (p_count_bound)
		else $error("queue overrun");

endmodule

@@ hw/rtl/vp8rtp_back.sv @@
// Back end: expands each queued word into descriptor and payload results,
// holding the result register. Depends on vp8rtp_pkg.
module vp8rtp_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  vp8rtp_pkg::cmd_t       head,
	input  vp8rtp_pkg::cmdq_stat_t q_stat,
	output logic                   q_rd,
	input  logic                   pop,
	output logic                   empty,
	output vp8rtp_pkg::out_item_t  result
);

	typedef enum logic [2:0] {
		PH_D0,
		PH_D1,
		PH_D2,
		PH_D3,
		PH_PAY
	} phase_t;

	phase_t                phase_q;
	phase_t                phase_nx;
	logic                  valid_q;
	vp8rtp_pkg::out_item_t result_q;
	vp8rtp_pkg::out_item_t word;
	logic                  load;
	logic                  last_word;

	assign load  = !q_stat.empty && (!valid_q || pop);
	assign q_rd  = load && last_word;
	assign empty = !valid_q;
	assign result = result_q;

	always_comb begin
		word.out_byte      = head.data_byte;
		word.end_of_packet = head.eop;
		word.marker        = head.mk;
		word.last_of_run   = 1'b1;
		last_word          = 1'b1;
		phase_nx           = PH_D0;
		unique case (phase_q)
			PH_D0: begin
				if (head.hdr) begin
					word.out_byte = vp8rtp_pkg::DescHighBit
						| {2'b00, head.noref, head.start, 4'h0};
					last_word = 1'b0;
					phase_nx  = PH_D1;
				end
			end
			PH_D1: begin
				word.out_byte = vp8rtp_pkg::DescHighBit;
				last_word     = 1'b0;
				phase_nx      = PH_D2;
			end
			PH_D2: begin
				word.out_byte = vp8rtp_pkg::DescHighBit
					| ({1'b0, head.pid[14:8]} & vp8rtp_pkg::PidHighMask);
				last_word     = 1'b0;
				phase_nx      = PH_D3;
			end
			PH_D3: begin
				word.out_byte = head.pid[7:0] & vp8rtp_pkg::ByteMask;
				last_word     = 1'b0;
				phase_nx      = PH_PAY;
			end
			PH_PAY: begin
			end
			default: begin
			end
		endcase
		// descriptor bytes never close a packet
		if (!last_word) begin
			word.end_of_packet = 1'b0;
			word.marker        = 1'b0;
			word.last_of_run   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_D0;
			valid_q  <= 1'b0;
			result_q <= '0;
		end else begin
			if (load) begin
				phase_q  <= phase_nx;
				valid_q  <= 1'b1;
				result_q <= word;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	property p_mid_word_has_head;
		@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_D0) |-> !q_stat.empty;
	endproperty
	a_mid_word_has_head: assert property (p_mid_word_has_head)
		else $error("descriptor in progress with no queued word");

	property p_desc_only_for_hdr;
		@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_D0) |-> head.hdr;
	endproperty
	a_desc_only_for_hdr: assert property (p_desc_only_for_hdr)
		else $error("descriptor bytes for a word without header");

	property p_marker_with_eop;
		@(posedge clk) disable iff (!arst_n)
		(valid_q && result_q.marker) |-> result_q.end_of_packet && result_q.last_of_run;
	endproperty
	a_marker_with_eop: assert property (p_marker_with_eop)
		else $error("marker outside packet end");

endmodule

@@ hw/rtl/vp8rtp_packetizer_core.sv @@
// VP8 RTP packetiser top level: front end, word queue, back end.
// Depends on vp8rtp_pkg, vp8rtp_front, vp8rtp_cmdq, vp8rtp_back.

// Takes one compressed byte per cycle while the word queue has room and emits
// VP8 RTP packets as a byte stream, each packet led by a four-byte payload
// descriptor with a 15-bit picture ID. A byte that continues an open packet
// yields one result word; the first byte of a packet yields five (four
// descriptor bytes, then the payload byte). The result side gives one word per
// cycle while words are queued and pop keeps up. The input side takes a byte
// every cycle while the four-entry word queue between front and back end has
// room; a byte passes that queue and the result register on its way out.
// packet_size must be written through cfg_we/cfg_data only while the block
// is idle, which the block itself does not enforce; values below 5 act as 5.
module vp8_rtp_packetizer_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  vp8rtp_pkg::in_item_t  item,
	input  logic                  pop,
	output logic                  empty,
	output vp8rtp_pkg::out_item_t result,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_data
);

	vp8rtp_pkg::cmdq_stat_t q_stat;
	vp8rtp_pkg::cmd_t       wr_cmd;
	vp8rtp_pkg::cmd_t       head;
	logic                   q_wr;
	logic                   q_rd;

	assign full = q_stat.full;

	vp8rtp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.q_stat   (q_stat),
		.q_wr     (q_wr),
		.q_cmd    (wr_cmd)
	);

	vp8rtp_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_cmd (wr_cmd),
		.rd     (q_rd),
		.rd_cmd (head),
		.stat   (q_stat)
	);

	vp8rtp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.q_rd   (q_rd),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

endmodule
